/* hdl/lsc_pkg.sv */
// lsc_pkg: shared constants and types for the line segment clipper.
// No dependencies; used by the interfaces and every module.
package lsc_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_BITS    = 4;
    localparam int NUM_BOUNDS      = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_MIN = 4'd0,
        REG_X_MAX = 4'd1,
        REG_Y_MIN = 4'd2,
        REG_Y_MAX = 4'd3
    } cfg_reg_t;

endpackage

/* hdl/lsc_if.sv */
// lsc_if: valid/ready channel interfaces for segments, results and config writes.
// Depends on lsc_pkg.
interface lsc_seg_if
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_res_if
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic signed [COORD_BITS-1:0] clip_start_x;
    logic signed [COORD_BITS-1:0] clip_start_y;
    logic signed [COORD_BITS-1:0] clip_end_x;
    logic signed [COORD_BITS-1:0] clip_end_y;

    modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                    clip_end_y, input ready);
    modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                    clip_end_y, output ready);
endinterface

interface lsc_cfg_if
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [CFG_IDX_BITS-1:0]      index;
    logic signed [COORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lsc_div_cell.sv */
// lsc_div_cell: one restoring-division step, producing one quotient bit per cycle in which en is high.
// Depends on lsc_pkg; chained by line_segment_clipper_core.
module lsc_div_cell
    import lsc_pkg::*;
#(
    parameter int SW = COORD_BITS_DEF + 3,
    parameter int QW = T_FRAC_BITS_DEF + 2
)(
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] rem_in,
    input  logic [SW-1:0] div_in,
    input  logic [QW-1:0] quo_in,
    input  logic          neg_in,
    input  logic          big_in,
    output logic [SW-1:0] rem_out,
    output logic [SW-1:0] div_out,
    output logic [QW-1:0] quo_out,
    output logic          neg_out,
    output logic          big_out
);

    logic          take;
    logic [SW-1:0] diff;

    assign take = rem_in >= div_in;
    assign diff = take ? rem_in - div_in : rem_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= {diff[SW-2:0], 1'b0};
            div_out <= div_in;
            quo_out <= {quo_in[QW-2:0], take};
            neg_out <= neg_in;
            big_out <= big_in;
        end
    end

endmodule

/* hdl/lsc_lerp.sv */
// lsc_lerp: start + d*t scaled by 2^-T, truncated toward zero and saturated; zero when ok is low.
// Two register stages. Depends on lsc_pkg.
module lsc_lerp
    import lsc_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         en,
    input  logic                         ok,
    input  logic signed [COORD_BITS-1:0] s,
    input  logic signed [COORD_BITS:0]   d,
    input  logic [T_FRAC_BITS:0]         t,
    output logic signed [COORD_BITS-1:0] result
);

    localparam int PW = COORD_BITS + T_FRAC_BITS + 3;
    localparam logic signed [PW:0] SMAX =
        (PW+1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PW:0] SMIN = -SMAX - (PW+1)'(1);
    localparam logic signed [PW-1:0] RND = PW'((64'sd1 <<< T_FRAC_BITS) - 64'sd1);

    logic signed [PW-1:0]         prod_reg;
    logic signed [COORD_BITS-1:0] s_reg;
    logic                         ok_reg;
    logic signed [PW-1:0]         adj;
    logic signed [PW-1:0]         shifted;
    logic signed [PW:0]           sum;
    logic signed [COORD_BITS-1:0] sat;

    always_comb
    begin
        adj     = prod_reg + (prod_reg[PW-1] ? RND : '0);
        shifted = adj >>> T_FRAC_BITS;
        sum     = {{(PW+1-COORD_BITS){s_reg[COORD_BITS-1]}}, s_reg} + {shifted[PW-1], shifted};
        if (sum > SMAX)
            sat = SMAX[COORD_BITS-1:0];
        else if (sum < SMIN)
            sat = SMIN[COORD_BITS-1:0];
        else
            sat = sum[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(d) * PW'($signed({1'b0, t}));
            s_reg    <= s;
            ok_reg   <= ok;
            result   <= ok_reg ? sat : '0;
        end
    end

endmodule

/* hdl/line_segment_clipper_core.sv */
// line_segment_clipper_core: Liang-Barsky clipping of 2D segments, top level.
// Depends on lsc_pkg, lsc_if, lsc_div_cell and lsc_lerp.
//
// Usage:
//  seg: segment transactions (start_x, start_y, end_x, end_y), signed Q4.12.
//  res: one result transaction per segment, in order: accepted flag plus the
//       clipped endpoints, all zero when the segment misses the window.
//  cfg: window register writes, index 0..3 = x_min, x_max, y_min, y_max;
//       other indexes are ignored. Write only while the block is idle.
// Throughput: one segment per cycle while no stall holds the pipeline. The four
//  boundary parameters are formed in parallel lanes by a chain of divider cells,
//  one quotient bit per cell.
// Reset: window returns to -1.0 .. +1.0 in both axes, pipeline is emptied.
// Stall: when res is not taken the whole pipeline holds and seg.ready drops;
//  the result register keeps its transaction until it is taken.
module line_segment_clipper_core
    import lsc_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    lsc_seg_if.sink      seg,
    lsc_res_if.source    res,
    lsc_cfg_if.sink      cfg
);

    localparam int C   = COORD_BITS;
    localparam int SW  = C + 3;
    localparam int QW  = T_FRAC_BITS + 2;
    localparam int NC  = QW;
    localparam int TW  = T_FRAC_BITS + 1;
    localparam int LAT = NC + 4;
    localparam logic signed [C-1:0] WIN_ONE = C'(64'sd1 <<< (C - 4));
    localparam logic [QW-1:0] T_ONE   = QW'(64'd1 << T_FRAC_BITS);
    localparam logic [QW-1:0] T_ONEP1 = T_ONE + QW'(1);

    logic signed [C-1:0] wx_min_reg, wx_max_reg, wy_min_reg, wy_max_reg;
    logic [LAT-1:0]      vld_reg;
    logic                en;

    assign en        = !vld_reg[LAT-1] || res.ready;
    assign seg.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_min_reg <= -WIN_ONE;
            wx_max_reg <= WIN_ONE;
            wy_min_reg <= -WIN_ONE;
            wy_max_reg <= WIN_ONE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_X_MIN: wx_min_reg <= cfg.data;
                REG_X_MAX: wx_max_reg <= cfg.data;
                REG_Y_MIN: wy_min_reg <= cfg.data;
                REG_Y_MAX: wy_max_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], seg.valid};
    end

    // boundary terms
    logic signed [C:0]   dx, dy;
    logic signed [C:0]   p [NUM_BOUNDS];
    logic signed [C:0]   q [NUM_BOUNDS];
    logic [SW-1:0]       rem0 [NUM_BOUNDS];
    logic [SW-1:0]       div0 [NUM_BOUNDS];
    logic                neg0 [NUM_BOUNDS];
    logic                big0 [NUM_BOUNDS];
    logic [NUM_BOUNDS-1:0] pneg0, zrej0;

    always_comb
    begin
        logic [C:0] qa, pa;
        dx   = {seg.end_x[C-1], seg.end_x} - {seg.start_x[C-1], seg.start_x};
        dy   = {seg.end_y[C-1], seg.end_y} - {seg.start_y[C-1], seg.start_y};
        p[0] = -dx;
        p[1] = dx;
        p[2] = -dy;
        p[3] = dy;
        q[0] = {seg.start_x[C-1], seg.start_x} - {wx_min_reg[C-1], wx_min_reg};
        q[1] = {wx_max_reg[C-1], wx_max_reg} - {seg.start_x[C-1], seg.start_x};
        q[2] = {seg.start_y[C-1], seg.start_y} - {wy_min_reg[C-1], wy_min_reg};
        q[3] = {wy_max_reg[C-1], wy_max_reg} - {seg.start_y[C-1], seg.start_y};
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            qa = q[i][C] ? -q[i] : q[i];
            pa = p[i][C] ? -p[i] : p[i];
            if (p[i] == '0)
            begin
                rem0[i]  = '0;
                div0[i]  = SW'(1);
                neg0[i]  = 1'b0;
                big0[i]  = 1'b0;
                pneg0[i] = 1'b1;
                zrej0[i] = q[i][C];
            end
            else
            begin
                rem0[i]  = SW'(qa);
                div0[i]  = SW'({pa, 1'b0});
                neg0[i]  = q[i][C] != p[i][C];
                big0[i]  = SW'(qa) >= SW'({pa, 2'b00});
                pneg0[i] = p[i][C];
                zrej0[i] = 1'b0;
            end
        end
    end

    // prep register and sideband line along the cell chain
    logic [SW-1:0]           rem_w [NUM_BOUNDS][NC+1];
    logic [SW-1:0]           div_w [NUM_BOUNDS][NC+1];
    logic [QW-1:0]           quo_w [NUM_BOUNDS][NC+1];
    logic                    neg_w [NUM_BOUNDS][NC+1];
    logic                    big_w [NUM_BOUNDS][NC+1];
    logic signed [C-1:0]     sx_reg [NC+1];
    logic signed [C-1:0]     sy_reg [NC+1];
    logic signed [C:0]       dx_reg [NC+1];
    logic signed [C:0]       dy_reg [NC+1];
    logic [NUM_BOUNDS-1:0]   pneg_reg [NC+1];
    logic [NUM_BOUNDS-1:0]   zrej_reg [NC+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg[0]   <= seg.start_x;
            sy_reg[0]   <= seg.start_y;
            dx_reg[0]   <= dx;
            dy_reg[0]   <= dy;
            pneg_reg[0] <= pneg0;
            zrej_reg[0] <= zrej0;
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                rem_w[i][0] <= rem0[i];
                div_w[i][0] <= div0[i];
                quo_w[i][0] <= '0;
                neg_w[i][0] <= neg0[i];
                big_w[i][0] <= big0[i];
            end
        end
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_chain
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sx_reg[k+1]   <= sx_reg[k];
                sy_reg[k+1]   <= sy_reg[k];
                dx_reg[k+1]   <= dx_reg[k];
                dy_reg[k+1]   <= dy_reg[k];
                pneg_reg[k+1] <= pneg_reg[k];
                zrej_reg[k+1] <= zrej_reg[k];
            end
        end
        for (genvar b = 0; b < NUM_BOUNDS; b++)
        begin : g_lane
            lsc_div_cell #(.SW(SW), .QW(QW)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_w[b][k]),
                .div_in  (div_w[b][k]),
                .quo_in  (quo_w[b][k]),
                .neg_in  (neg_w[b][k]),
                .big_in  (big_w[b][k]),
                .rem_out (rem_w[b][k+1]),
                .div_out (div_w[b][k+1]),
                .quo_out (quo_w[b][k+1]),
                .neg_out (neg_w[b][k+1]),
                .big_out (big_w[b][k+1])
            );
        end
    end

    // resolve t0 / t1
    logic [QW-1:0] t0_c, t1_c;
    logic          rej_c;

    always_comb
    begin
        logic [QW-1:0] m;
        logic          negv;
        t0_c  = '0;
        t1_c  = T_ONE;
        rej_c = |zrej_reg[NC];
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            negv = neg_w[i][NC] && (big_w[i][NC] || quo_w[i][NC] != '0);
            m    = (big_w[i][NC] || quo_w[i][NC] > T_ONEP1) ? T_ONEP1 : quo_w[i][NC];
            if (pneg_reg[NC][i])
            begin
                if (!negv && m > t0_c)
                    t0_c = m;
            end
            else
            begin
                if (negv)
                    rej_c = 1'b1;
                else if (m < t1_c)
                    t1_c = m;
            end
        end
        if (t0_c > t1_c)
            rej_c = 1'b1;
    end

    logic              ok_reg;
    logic [TW-1:0]     t0_reg, t1_reg;
    logic signed [C-1:0] sx_r, sy_r;
    logic signed [C:0]   dx_r, dy_r;
    logic              ok_d_reg, acc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg   <= !rej_c;
            t0_reg   <= TW'(t0_c);
            t1_reg   <= TW'(t1_c);
            sx_r     <= sx_reg[NC];
            sy_r     <= sy_reg[NC];
            dx_r     <= dx_reg[NC];
            dy_r     <= dy_reg[NC];
            ok_d_reg <= ok_reg;
            acc_reg  <= ok_d_reg;
        end
    end

    lsc_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_sx (
        .clk(clk), .en(en), .ok(ok_reg), .s(sx_r), .d(dx_r), .t(t0_reg),
        .result(res.clip_start_x)
    );
    lsc_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_sy (
        .clk(clk), .en(en), .ok(ok_reg), .s(sy_r), .d(dy_r), .t(t0_reg),
        .result(res.clip_start_y)
    );
    lsc_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_ex (
        .clk(clk), .en(en), .ok(ok_reg), .s(sx_r), .d(dx_r), .t(t1_reg),
        .result(res.clip_end_x)
    );
    lsc_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_ey (
        .clk(clk), .en(en), .ok(ok_reg), .s(sy_r), .d(dy_r), .t(t1_reg),
        .result(res.clip_end_y)
    );

    assign res.valid    = vld_reg[LAT-1];
    assign res.accepted = acc_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.accepted |-> res.clip_start_x == '0 && res.clip_start_y == '0
            && res.clip_end_x == '0 && res.clip_end_y == '0)
        else $error("rejected segment with nonzero coordinates");

    a_t_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NC+1] && ok_reg |-> t0_reg <= t1_reg)
        else $error("accepted segment with t0 above t1");

    a_t1_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NC+1] |-> TW'(t1_reg) <= TW'(T_ONE))
        else $error("t1 above one");

endmodule
